@@ hdl/irdf_pkg.sv @@
// shared types and constants of the ir ring direction finder
// no dependencies
`default_nettype none

package irdf_pkg;

  localparam int MAX_SENSORS = 8;
  localparam int IDX_W       = $clog2(MAX_SENSORS);
  localparam int CNT_W       = 4;
  localparam int ANG_W       = 16;
  localparam int DIR_W       = 13;
  localparam int NUM_W       = 24;
  localparam int DEN_W       = 7;
  localparam int DVD_W       = NUM_W + 4;
  localparam int DIV_STEPS   = DVD_W / 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int WALK_LEN    = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENSOR_COUNT  = 3'd0,
    REG_COUNT_LIMIT   = 3'd1,
    REG_ANY_THRESHOLD = 3'd2,
    REG_ANGLES_LOW    = 3'd3,
    REG_ANGLES_HIGH   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [3:0]            sensor_count;
    logic [CNT_W-1:0]      count_limit;
    logic [CNT_W-1:0]      any_threshold;
    logic [CFG_DATA_W-1:0] angles_low;
    logic [CFG_DATA_W-1:0] angles_high;
  } cfg_t;

  typedef struct packed {
    logic             update;
    logic             scan;
    logic             walk;
    logic             div_load;
    logic             div_step;
    logic             fold;
    logic             load_out;
    logic [IDX_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
  } sts_t;

endpackage

`default_nettype wire

@@ hdl/irdf_ctrl.sv @@
// sequencer of the ir ring direction finder: scan, window walk, divide, fold
// depends on irdf_pkg
`default_nettype none

module irdf_ctrl
  import irdf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WALK,
    S_DIV,
    S_FOLD,
    S_HOLD
  } state_t;

  state_t     state_r;
  logic [3:0] step_r;
  logic       out_valid_r;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd      = '0;
    cmd.step = step_r[IDX_W-1:0];
    unique case (state_r)
      S_IDLE: cmd.update = in_valid;
      S_SCAN: cmd.scan = 1'b1;
      S_WALK: cmd.walk = 1'b1;
      S_DIV: begin
        cmd.div_load = (step_r == 4'd0);
        cmd.div_step = (step_r != 4'd0);
      end
      S_FOLD: cmd.fold = 1'b1;
      S_HOLD: cmd.load_out = !out_valid_r || !out_stall;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.load_out || (out_valid_r && out_stall);
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_SCAN;
            step_r  <= 4'd0;
          end
        end
        S_SCAN: begin
          if (sts.scan_last) begin
            state_r <= S_WALK;
            step_r  <= 4'd0;
          end else begin
            step_r <= step_r + 4'd1;
          end
        end
        S_WALK: begin
          if (step_r == 4'(WALK_LEN - 1)) begin
            state_r <= S_DIV;
            step_r  <= 4'd0;
          end else begin
            step_r <= step_r + 4'd1;
          end
        end
        S_DIV: begin
          if (step_r == 4'(DIV_STEPS)) begin
            state_r <= S_FOLD;
            step_r  <= 4'd0;
          end else begin
            step_r <= step_r + 4'd1;
          end
        end
        S_FOLD: state_r <= S_HOLD;
        S_HOLD: begin
          if (cmd.load_out) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/irdf_datapath.sv @@
// datapath of the ir ring direction finder: hit counters, peak scan,
// weighted window accumulation, 2-bit-per-cycle divider, fold and result register
// depends on irdf_pkg
`default_nettype none

module irdf_datapath
  import irdf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_t              cfg,
  input  wire cmd_t              cmd,
  input  wire logic [MAX_SENSORS-1:0] in_sensor_levels,
  output sts_t                   sts,
  output logic                   out_source_found,
  output logic signed [DIR_W-1:0] out_direction,
  output logic                   out_above_threshold
);

  localparam int PROD_W = ANG_W + 1 + CNT_W + 1;
  localparam int FOLD_W = DVD_W + 1;
  localparam logic signed [FOLD_W-1:0] LIM_POS = FOLD_W'(2880);
  localparam logic signed [FOLD_W-1:0] LIM_NEG = -FOLD_W'(2880);
  localparam logic signed [FOLD_W-1:0] SPAN    = FOLD_W'(5760);
  localparam logic [IDX_W-1:0] OFF_SKIP = IDX_W'(5);

  logic [CNT_W-1:0]         cnt_r [MAX_SENSORS];
  logic [IDX_W-1:0]         best_r;
  logic [5:0]               best_sum_r;
  logic                     above_r;
  logic                     wrapped_r;
  logic signed [NUM_W-1:0]  num_r;
  logic [DEN_W-1:0]         den_r;
  logic [DVD_W-1:0]         q_r;
  logic [DEN_W-1:0]         rem_r;
  logic                     neg_r;
  logic signed [DIR_W-1:0]  dir_r;

  logic [3:0]               n_fit;
  logic [IDX_W-1:0]         n_last;
  logic [IDX_W-1:0]         left_idx;
  logic [IDX_W-1:0]         right_idx;
  logic [5:0]               scan_sum;
  logic signed [4:0]        wi;
  logic [IDX_W-1:0]         widx;
  logic                     wrapped_now;
  logic [2*MAX_SENSORS*ANG_W/2-1:0] ang_all;
  logic signed [ANG_W:0]    ang_w;
  logic signed [PROD_W-1:0] prod;
  logic [DEN_W:0]           dstep1;
  logic [DEN_W:0]           dstep2;
  logic signed [NUM_W-1:0]  num_abs;
  logic signed [FOLD_W-1:0] qs;
  logic signed [FOLD_W-1:0] fd;
  logic signed [DIR_W-1:0]  dir_sat;

  function automatic logic [DEN_W:0] div_bit(input logic [DEN_W-1:0] rem,
                                             input logic b,
                                             input logic [DEN_W-1:0] d);
    logic [DEN_W:0] t;
    t = {rem, b};
    if (t >= {1'b0, d}) begin
      return {1'b1, DEN_W'(t - {1'b0, d})};
    end else begin
      return {1'b0, t[DEN_W-1:0]};
    end
  endfunction

  assign ang_all = {cfg.angles_high, cfg.angles_low};

  always_comb begin
    priority if (cfg.sensor_count > 4'(MAX_SENSORS)) begin
      n_fit = 4'(MAX_SENSORS);
    end else if (cfg.sensor_count < 4'd4) begin
      n_fit = 4'd4;
    end else begin
      n_fit = cfg.sensor_count;
    end
  end

  assign n_last        = IDX_W'(n_fit - 4'd1);
  assign sts.scan_last = (cmd.step == n_last);

  // ring neighbours of the scanned sensor
  assign left_idx  = (cmd.step == '0) ? n_last : cmd.step - IDX_W'(1);
  assign right_idx = (cmd.step == n_last) ? '0 : cmd.step + IDX_W'(1);
  assign scan_sum  = 6'(cnt_r[cmd.step]) + 6'(cnt_r[left_idx]) + 6'(cnt_r[right_idx]);

  // window position, offsets -3..+3 around the peak
  always_comb begin
    wi = $signed({2'b00, best_r}) + $signed({2'b00, cmd.step}) - 5'sd3;
    priority if (wi < 5'sd0) begin
      wi = wi + $signed({1'b0, n_fit});
    end else if (wi >= $signed({1'b0, n_fit})) begin
      wi = wi - $signed({1'b0, n_fit});
    end
    widx = wi[IDX_W-1:0];
  end

  assign wrapped_now = ((cmd.step != '0) && wrapped_r) ||
                       ((cmd.step != OFF_SKIP) && (widx == '0));
  assign ang_w = $signed({ang_all[widx*ANG_W+ANG_W-1], ang_all[widx*ANG_W +: ANG_W]}) +
                 (wrapped_now ? (ANG_W+1)'(360) : '0);
  assign prod  = ang_w * $signed({1'b0, cnt_r[widx]});

  assign dstep1 = div_bit(rem_r, q_r[DVD_W-1], den_r);
  assign dstep2 = div_bit(dstep1[DEN_W-1:0], q_r[DVD_W-2], den_r);

  assign num_abs = num_r[NUM_W-1] ? -num_r : num_r;

  always_comb begin
    qs = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
    priority if (qs < LIM_NEG) begin
      fd = qs + SPAN;
    end else if (qs > LIM_POS) begin
      fd = qs - SPAN;
    end else begin
      fd = qs;
    end
    priority if (fd < LIM_NEG) begin
      dir_sat = DIR_W'(LIM_NEG);
    end else if (fd > LIM_POS) begin
      dir_sat = DIR_W'(LIM_POS);
    end else begin
      dir_sat = fd[DIR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_SENSORS; k++) begin
        cnt_r[k] <= '0;
      end
    end else if (cmd.update) begin
      for (int k = 0; k < MAX_SENSORS; k++) begin
        if (4'(k) < n_fit) begin
          if (!in_sensor_levels[k]) begin
            if (cnt_r[k] < cfg.count_limit) begin
              cnt_r[k] <= cnt_r[k] + CNT_W'(1);
            end
          end else if (cnt_r[k] != '0) begin
            cnt_r[k] <= cnt_r[k] - CNT_W'(1);
          end
        end
      end
    end

    if (cmd.scan) begin
      if (cmd.step == '0) begin
        best_r     <= '0;
        best_sum_r <= scan_sum;
        above_r    <= (cnt_r[cmd.step] > cfg.any_threshold);
      end else begin
        if (scan_sum > best_sum_r) begin
          best_r     <= cmd.step;
          best_sum_r <= scan_sum;
        end
        if (cnt_r[cmd.step] > cfg.any_threshold) begin
          above_r <= 1'b1;
        end
      end
    end

    if (cmd.walk) begin
      wrapped_r <= wrapped_now;
      if (cmd.step == '0) begin
        num_r <= NUM_W'(prod);
        den_r <= DEN_W'(cnt_r[widx]);
      end else begin
        num_r <= num_r + NUM_W'(prod);
        den_r <= den_r + DEN_W'(cnt_r[widx]);
      end
    end

    if (cmd.div_load) begin
      q_r   <= {num_abs[NUM_W-1:0], 4'b0000};
      rem_r <= '0;
      neg_r <= num_r[NUM_W-1];
    end else if (cmd.div_step) begin
      q_r   <= {q_r[DVD_W-3:0], dstep1[DEN_W], dstep2[DEN_W]};
      rem_r <= dstep2[DEN_W-1:0];
    end

    if (cmd.fold) begin
      dir_r <= dir_sat;
    end

    if (cmd.load_out) begin
      out_source_found    <= (den_r != '0);
      out_direction       <= (den_r != '0) ? dir_r : '0;
      out_above_threshold <= above_r;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ir_ring_direction_finder.sv @@
// ir ring direction finder, top level: configuration registers, sequencer, datapath
// the sensor count is fitted to 4..8; one input at a time, the next is taken only once
// the last result is loaded; the scan walks one sensor per cycle and the divider
// retires two quotient bits per cycle
// reset: synchronous active-low rst_n clears the sequencer and hit counters
// and restores register defaults; depends on irdf_pkg, irdf_ctrl, irdf_datapath
`default_nettype none

module ir_ring_direction_finder
  import irdf_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [MAX_SENSORS-1:0] in_sensor_levels,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        out_source_found,
  output logic signed [DIR_W-1:0]     out_direction,
  output logic                        out_above_threshold,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sensor_count  <= 4'(MAX_SENSORS);
      cfg_r.count_limit   <= CNT_W'(2);
      cfg_r.any_threshold <= '0;
      cfg_r.angles_low    <= '0;
      cfg_r.angles_high   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SENSOR_COUNT:  cfg_r.sensor_count  <= cfg_data[3:0];
        REG_COUNT_LIMIT:   cfg_r.count_limit   <= cfg_data[CNT_W-1:0];
        REG_ANY_THRESHOLD: cfg_r.any_threshold <= cfg_data[CNT_W-1:0];
        REG_ANGLES_LOW:    cfg_r.angles_low    <= cfg_data;
        REG_ANGLES_HIGH:   cfg_r.angles_high   <= cfg_data;
        default: ;
      endcase
    end
  end

  irdf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  irdf_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .cmd                 (cmd),
    .in_sensor_levels    (in_sensor_levels),
    .sts                 (sts),
    .out_source_found    (out_source_found),
    .out_direction       (out_direction),
    .out_above_threshold (out_above_threshold)
  );

endmodule

`default_nettype wire

@@ hdl/irdf_checker.sv @@
// port-level checks for the ir ring direction finder, bound to the top level
// depends on irdf_pkg
`default_nettype none

module irdf_checker
  import irdf_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_stall,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire logic                   out_source_found,
  input wire logic signed [DIR_W-1:0] out_direction
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_direction))
    else $error("result dropped or changed under stall");

  // no weight means no direction
  a_no_src_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_source_found |-> out_direction == '0)
    else $error("direction nonzero without source");

  // direction stays within one half turn
  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_direction >= -13'sd2880) && (out_direction <= 13'sd2880))
    else $error("direction out of range");

  // one item at a time: busy right after an input transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second input taken while busy");

endmodule

bind ir_ring_direction_finder irdf_checker u_irdf_checker (.*);

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// testbench for ir_ring_direction_finder: random and directed sensor ticks with a
// bearing predictor in a small class, random input gaps and random result stalls
// depends on irdf_pkg and the ir_ring_direction_finder rtl

module testbench;
  import irdf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd5;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 112;
  localparam int PHASES        = 12;

  typedef enum {ANG_RING, ANG_RANDOM, ANG_EXTREME} angle_set_t;

  typedef struct {
    logic                    found;
    logic signed [DIR_W-1:0] direction;
    logic                    above;
  } bearing_t;

  class bearing_tracker;
    cfg_t regs;
    logic [CNT_W-1:0] hits [MAX_SENSORS];
    bearing_t expected_bearings [$];
    int errors;

    function new();
      regs.sensor_count  = 4'd8;
      regs.count_limit   = 4'd2;
      regs.any_threshold = 4'd0;
      regs.angles_low    = '0;
      regs.angles_high   = '0;
      foreach (hits[k]) hits[k] = '0;
      errors = 0;
    endfunction

    task report(string what);
      errors++;
      $display("%0t mismatch: %s", $realtime, what);
    endtask

    function int pending();
      return expected_bearings.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SENSOR_COUNT:  regs.sensor_count  = data[3:0];
        REG_COUNT_LIMIT:   regs.count_limit   = data[CNT_W-1:0];
        REG_ANY_THRESHOLD: regs.any_threshold = data[CNT_W-1:0];
        REG_ANGLES_LOW:    regs.angles_low    = data;
        REG_ANGLES_HIGH:   regs.angles_high   = data;
        default: ;
      endcase
    endfunction

    function longint angle_of(int k);
      logic [CFG_DATA_W-1:0] w;
      w = (k < 4) ? regs.angles_low : regs.angles_high;
      return longint'($signed(w[(k % 4) * ANG_W +: ANG_W]));
    endfunction

    // advances the hit counters and queues the bearing this tick produces
    function void note_input(logic [MAX_SENSORS-1:0] levels);
      int n, best, best_sum, s, left, right, idx;
      bit wrapped, above;
      longint num, den, dir, ang;
      bearing_t r;
      n = (regs.sensor_count > MAX_SENSORS) ? MAX_SENSORS :
          ((regs.sensor_count < 4) ? 4 : int'(regs.sensor_count));
      best = 0;
      best_sum = -1;
      wrapped = 0;
      above = 0;
      num = 0;
      den = 0;
      dir = 0;
      for (int k = 0; k < n; k++) begin
        if (!levels[k]) begin
          if (hits[k] < regs.count_limit) hits[k] = hits[k] + 1'b1;
        end else if (hits[k] > 0) begin
          hits[k] = hits[k] - 1'b1;
        end
      end
      for (int k = 0; k < n; k++) begin
        left  = (k == 0) ? n - 1 : k - 1;
        right = (k == n - 1) ? 0 : k + 1;
        s = int'(hits[k]) + int'(hits[left]) + int'(hits[right]);
        if (s > best_sum) begin
          best_sum = s;
          best = k;
        end
        if (hits[k] > regs.any_threshold) above = 1;
      end
      for (int off = -3; off <= 3; off++) begin
        idx = best + off;
        if (idx < 0) idx += n;
        if (idx >= n) idx -= n;
        idx &= 7;
        if (off != 2 && idx == 0) wrapped = 1;
        ang = angle_of(idx);
        if (wrapped) ang += 360;
        num += ang * longint'(hits[idx]);
        den += longint'(hits[idx]);
      end
      if (den != 0) begin
        dir = (num * 16) / den;
        if (dir < -2880) dir += 5760;
        else if (dir > 2880) dir -= 5760;
        if (dir < -2880) dir = -2880;
        if (dir > 2880) dir = 2880;
      end
      r.found = (den != 0);
      r.direction = dir[DIR_W-1:0];
      r.above = above;
      expected_bearings.push_back(r);
    endfunction

    task check_result(logic found, logic signed [DIR_W-1:0] direction, logic above);
      bearing_t e;
      if (expected_bearings.size() == 0) begin
        report("result transfer with nothing expected");
        return;
      end
      e = expected_bearings.pop_front();
      if (found !== e.found)
        report($sformatf("source_found %b, expected %b", found, e.found));
      if (direction !== e.direction)
        report($sformatf("direction %0d, expected %0d", direction, e.direction));
      if (above !== e.above)
        report($sformatf("above_threshold %b, expected %b", above, e.above));
    endtask

    task check_drained();
      if (expected_bearings.size() != 0)
        report($sformatf("%0d results never arrived", expected_bearings.size()));
    endtask
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [MAX_SENSORS-1:0] in_sensor_levels;
  logic                   out_valid;
  logic                   out_stall;
  logic                   out_source_found;
  logic signed [DIR_W-1:0] out_direction;
  logic                   out_above_threshold;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  bearing_tracker tracker = new();
  bit in_idle = 1;
  bit out_idle = 1;
  bit hold_long = 0;
  int ring_n = 8;
  int arc_pos = 0;

  ir_ring_direction_finder dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sensor_levels    (in_sensor_levels),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_source_found    (out_source_found),
    .out_direction       (out_direction),
    .out_above_threshold (out_above_threshold),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #7_200_000;
    $display("** ir_ring_direction_finder: FAILED **");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) tracker.note_input(in_sensor_levels);
      if (out_valid && !out_stall)
        tracker.check_result(out_source_found, out_direction, out_above_threshold);
    end
  end

  // result side: random stall before each transfer when out_idle is set, one long hold on request
  initial begin : receiver
    int hold;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      hold = out_idle ? $urandom_range(0, 9) : 0;
      if (hold_long) begin
        hold = 400;
        hold_long = 0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_levels(input logic [MAX_SENSORS-1:0] levels);
    int gap;
    gap = in_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sensor_levels <= levels;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [3:0] sc, input logic [3:0] lim, input logic [3:0] thr,
                           input logic [63:0] alo, input logic [63:0] ahi,
                           input bit poke_spare);
    logic [CFG_IDX_W-1:0] idx [$];
    logic [CFG_DATA_W-1:0] val [$];
    if (poke_spare) begin
      idx.push_back(REG_SPARE);
      val.push_back({$urandom, $urandom});
    end
    idx.push_back(REG_SENSOR_COUNT);
    val.push_back(64'(sc));
    idx.push_back(REG_COUNT_LIMIT);
    val.push_back(64'(lim));
    idx.push_back(REG_ANY_THRESHOLD);
    val.push_back(64'(thr));
    idx.push_back(REG_ANGLES_LOW);
    val.push_back(alo);
    idx.push_back(REG_ANGLES_HIGH);
    val.push_back(ahi);
    foreach (idx[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [127:0] ring_angles(int n, angle_set_t mode);
    logic [127:0] a;
    int base, v;
    base = int'($urandom_range(0, 360)) - 180;
    for (int k = 0; k < 8; k++) begin
      case (mode)
        ANG_RING: begin
          v = base + (k * 360) / n + int'($urandom_range(0, 6)) - 3;
          if (v > 180) v -= 360;
        end
        ANG_RANDOM: v = $urandom;
        default: v = $urandom_range(0, 1) ? 32767 : -32768;
      endcase
      a[k*16 +: 16] = v[15:0];
    end
    return a;
  endfunction

  // mostly a lit arc drifting around the ring, with noise and blank ticks
  function automatic logic [MAX_SENSORS-1:0] next_levels();
    logic [MAX_SENSORS-1:0] lv;
    int w;
    arc_pos = arc_pos % ring_n;
    case ($urandom_range(0, 9))
      0: lv = MAX_SENSORS'($urandom);
      1: lv = '1;
      2: lv = '0;
      default: begin
        case ($urandom_range(0, 3))
          0: arc_pos = (arc_pos + 1) % ring_n;
          1: arc_pos = (arc_pos + ring_n - 1) % ring_n;
          default: ;
        endcase
        w = $urandom_range(1, 3);
        lv = '1;
        for (int j = 0; j < w; j++) lv[(arc_pos + j) % ring_n] = 1'b0;
        if ($urandom_range(0, 7) == 0) lv[$urandom_range(0, 7)] ^= 1'b1;
        for (int j = ring_n; j < MAX_SENSORS; j++) lv[j] = 1'($urandom_range(0, 1));
      end
    endcase
    return lv;
  endfunction

  initial begin : stimulus
    logic [127:0] ang;
    logic [3:0] sc, lim, thr;
    angle_set_t amode;
    int c;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_sensor_levels <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults straight after reset
    send_levels(8'hFF);
    send_levels(8'h00);
    send_levels(8'h00);
    send_levels(8'h0F);
    drain();

    // eight-sensor ring at 45 degree steps, high limit and threshold
    configure(4'd8, 4'd15, 4'd15, 64'h0087_005A_002D_0000, 64'hFFD3_FFA6_FF79_00B4, 1);
    repeat (5) send_levels(8'h00);
    send_levels(8'h7F);
    send_levels(8'hFF);
    drain();

    // count below range, zero limit, extreme angles, unfitted bits toggling
    configure(4'd0, 4'd0, 4'd0, 64'h7FFF_8000_7FFF_8000, 64'h8000_7FFF_8000_7FFF, 0);
    send_levels(8'hF0);
    send_levels(8'h0A);
    send_levels(8'h05);
    drain();

    // count above range, limit below current counts
    configure(4'd15, 4'd1, 4'd0, 64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF, 0);
    send_levels(8'h00);
    send_levels(8'hAA);
    send_levels(8'h55);
    drain();

    // five-sensor ring with the source on sensor 0 so the mean wraps and folds
    configure(4'd5, 4'd15, 4'd3, 64'hFF70_0090_0048_0000, 64'h0000_0000_0000_FFB8, 0);
    send_levels(8'hFE);
    send_levels(8'hFE);
    send_levels(8'hFC);
    send_levels(8'hFF);
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin sc = 4'd4; lim = 4'd15; thr = 4'd0; end
        1: begin sc = 4'd8; lim = 4'd1; thr = 4'd15; end
        2: begin sc = 4'd8; lim = 4'd15; thr = 4'd14; end
        default: begin
          sc = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(4, 8));
          lim = ($urandom_range(0, 7) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
          thr = 4'($urandom_range(0, 15));
        end
      endcase
      ring_n = (sc > 8) ? 8 : ((sc < 4) ? 4 : int'(sc));
      if ($urandom_range(0, 4) < 3) amode = ANG_RING;
      else amode = $urandom_range(0, 1) ? ANG_RANDOM : ANG_EXTREME;
      ang = ring_angles(ring_n, amode);
      configure(sc, lim, thr, ang[63:0], ang[127:64], phase == 5);
      in_idle = (phase % 4 != 1);
      out_idle = (phase % 3 != 2);
      if (phase == 2) hold_long = 1;
      for (int i = 0; i < PHASE_ITEMS; i++) send_levels(next_levels());
      drain();
    end

    in_valid <= 1'b0;
    for (c = 0; c < 5000 && tracker.pending() != 0; c++) @(posedge clk);
    tracker.check_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0)
      $display("** ir_ring_direction_finder: PASSED **");
    else
      $display("** ir_ring_direction_finder: FAILED **");
    $finish;
  end

endmodule
